[design/rbb_pkg.sv]
`timescale 1ns / 1ps
package rbb_pkg;

	// Fixed field widths of the channels and the configuration port.
	localparam int CHAN_W      = 8;
	localparam int PIX_W       = 3 * CHAN_W;
	localparam int RADIUS_W    = 3;
	localparam int FWIDTH_W    = 12;
	localparam int FHEIGHT_W   = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 2;
	localparam int QUOT_W      = 8;

	// Register values after reset.
	localparam logic [RADIUS_W-1:0]  RADIUS_RST  = 3'd1;
	localparam logic [FWIDTH_W-1:0]  FWIDTH_RST  = 12'd640;
	localparam logic [FHEIGHT_W-1:0] FHEIGHT_RST = 13'd480;

	// Request kinds on the pixel channel.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_RADIUS  = 2'd0,
		CFG_FWIDTH  = 2'd1,
		CFG_FHEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_BACK,
		ST_READ,
		ST_FLUSH,
		ST_LOAD,
		ST_DIV,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_pix;
		logic win_init;
		logic back_step;
		logic read_step;
		logic div_init;
		logic div_step;
		logic emit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_done;
		logic emit_ready;
		logic k_zero;
		logic win_last;
		logic div_last;
		logic out_free;
	} dp_stat_t;

endpackage

[design/rbb_ifs.sv]
`timescale 1ns / 1ps
// Pixel request channel.
interface rbb_pix_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [rbb_pkg::CHAN_W-1:0] in_red;
	logic [rbb_pkg::CHAN_W-1:0] in_green;
	logic [rbb_pkg::CHAN_W-1:0] in_blue;

	modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
	modport sink (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

// Blurred pixel channel.
interface rbb_out_if;
	logic                       valid;
	logic                       ready;
	logic [rbb_pkg::CHAN_W-1:0] out_red;
	logic [rbb_pkg::CHAN_W-1:0] out_green;
	logic [rbb_pkg::CHAN_W-1:0] out_blue;
	logic                       frame_end;

	modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
	modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

[design/rbb_ctrl.sv]
`timescale 1ns / 1ps
module rbb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_cmd,
	output logic                in_ready,
	input  rbb_pkg::dp_stat_t   stat,
	output rbb_pkg::ctrl_cmd_t  ctl
);

	rbb_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencing of one request: store, check, window walk, divide, hand off.
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			rbb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.wr_pix = (in_cmd == rbb_pkg::CMD_PIXEL) && !stat.in_done;
					state_d    = rbb_pkg::ST_CHECK;
				end
			end
			rbb_pkg::ST_CHECK: begin
				if (stat.emit_ready) begin
					ctl.win_init = 1'b1;
					state_d      = rbb_pkg::ST_BACK;
				end else begin
					state_d = rbb_pkg::ST_IDLE;
				end
			end
			rbb_pkg::ST_BACK: begin
				if (stat.k_zero) begin
					state_d = rbb_pkg::ST_READ;
				end else begin
					ctl.back_step = 1'b1;
				end
			end
			rbb_pkg::ST_READ: begin
				ctl.read_step = 1'b1;
				if (stat.win_last) begin
					state_d = rbb_pkg::ST_FLUSH;
				end
			end
			rbb_pkg::ST_FLUSH: begin
				state_d = rbb_pkg::ST_LOAD;
			end
			rbb_pkg::ST_LOAD: begin
				ctl.div_init = 1'b1;
				state_d      = rbb_pkg::ST_DIV;
			end
			rbb_pkg::ST_DIV: begin
				ctl.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = rbb_pkg::ST_EMIT;
				end
			end
			rbb_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					ctl.emit = 1'b1;
					state_d  = rbb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rbb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[design/rbb_dp.sv]
`timescale 1ns / 1ps
module rbb_dp #(
	parameter int MAX_RADIUS = 7,
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rbb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rbb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [rbb_pkg::CHAN_W-1:0]      pix_red,
	input  logic [rbb_pkg::CHAN_W-1:0]      pix_green,
	input  logic [rbb_pkg::CHAN_W-1:0]      pix_blue,
	input  rbb_pkg::ctrl_cmd_t              ctl,
	output rbb_pkg::dp_stat_t               stat,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [rbb_pkg::CHAN_W-1:0]      out_red,
	output logic [rbb_pkg::CHAN_W-1:0]      out_green,
	output logic [rbb_pkg::CHAN_W-1:0]      out_blue,
	output logic                            out_frame_end
);

	localparam int DEPTH    = MAX_RADIUS * MAX_WIDTH;
	localparam int AW       = $clog2(DEPTH);
	localparam int AX       = AW + 1;
	localparam int CW       = $clog2(MAX_WIDTH);
	localparam int WW       = $clog2(MAX_WIDTH + 1);
	localparam int RW       = $clog2(MAX_HEIGHT);
	localparam int HW       = $clog2(MAX_HEIGHT + 1);
	localparam int MAX_SIDE = (MAX_RADIUS % 2 == 1) ? MAX_RADIUS : MAX_RADIUS - 1;
	localparam int SDW      = $clog2(MAX_SIDE + 1);
	localparam int MAX_AREA = MAX_SIDE * MAX_SIDE;
	localparam int AREA_W   = $clog2(MAX_AREA + 1);
	localparam int SUM_W    = $clog2(MAX_AREA * (2 ** rbb_pkg::CHAN_W - 1) + 1);
	localparam int DCW      = $clog2(rbb_pkg::QUOT_W);
	localparam int CH       = rbb_pkg::CHAN_W;

	// Configuration registers.
	logic [rbb_pkg::RADIUS_W-1:0]  radius_q;
	logic [rbb_pkg::FWIDTH_W-1:0]  fwidth_q;
	logic [rbb_pkg::FHEIGHT_W-1:0] fheight_q;
	logic                          cfg_hit;

	assign cfg_hit = cfg_we && (cfg_index == rbb_pkg::CFG_RADIUS
		|| cfg_index == rbb_pkg::CFG_FWIDTH || cfg_index == rbb_pkg::CFG_FHEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= rbb_pkg::RADIUS_RST;
			fwidth_q  <= rbb_pkg::FWIDTH_RST;
			fheight_q <= rbb_pkg::FHEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == rbb_pkg::CFG_RADIUS) begin
				radius_q <= cfg_data[rbb_pkg::RADIUS_W-1:0];
			end
			if (cfg_index == rbb_pkg::CFG_FWIDTH) begin
				fwidth_q <= cfg_data[rbb_pkg::FWIDTH_W-1:0];
			end
			if (cfg_index == rbb_pkg::CFG_FHEIGHT) begin
				fheight_q <= cfg_data[rbb_pkg::FHEIGHT_W-1:0];
			end
		end
	end

	// Effective window side and frame size after clamping.
	logic [SDW-1:0]    side, half, side_m1;
	logic [WW-1:0]     w;
	logic [HW-1:0]     h;
	logic [CW-1:0]     wm1;
	logic [RW-1:0]     hm1;
	logic [AREA_W-1:0] area;

	always_comb begin
		if (32'(radius_q | rbb_pkg::RADIUS_W'(1)) > 32'(MAX_SIDE)) begin
			side = SDW'(MAX_SIDE);
		end else begin
			side = SDW'(radius_q | rbb_pkg::RADIUS_W'(1));
		end
		if (fwidth_q == '0) begin
			w = WW'(1);
		end else if (32'(fwidth_q) > 32'(MAX_WIDTH)) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(fwidth_q);
		end
		if (fheight_q == '0) begin
			h = HW'(1);
		end else if (32'(fheight_q) > 32'(MAX_HEIGHT)) begin
			h = HW'(MAX_HEIGHT);
		end else begin
			h = HW'(fheight_q);
		end
	end

	assign half    = side >> 1;
	assign side_m1 = side - SDW'(1);
	assign wm1     = CW'(w - WW'(1));
	assign hm1     = RW'(h - HW'(1));
	assign area    = AREA_W'(32'(side) * 32'(side));

	// Frame positions and ring addresses.
	logic [RW-1:0] in_row_q, out_row_q;
	logic [CW-1:0] in_col_q, out_col_q;
	logic [AW-1:0] in_addr_q, out_rb_q;
	logic          in_done_q;
	logic          last_px;
	logic [AX-1:0] out_rb_inc;

	assign last_px    = (out_row_q == hm1) && (out_col_q == wm1);
	assign out_rb_inc = AX'(out_rb_q) + AX'(w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			in_addr_q <= '0;
			out_rb_q  <= '0;
			in_done_q <= 1'b0;
		end else if (cfg_hit || (ctl.emit && last_px)) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			in_addr_q <= '0;
			out_rb_q  <= '0;
			in_done_q <= 1'b0;
		end else begin
			if (ctl.wr_pix) begin
				in_addr_q <= (32'(in_addr_q) == DEPTH - 1) ? '0 : in_addr_q + AW'(1);
				if (in_col_q >= wm1) begin
					in_col_q <= '0;
					if (in_row_q >= hm1) begin
						in_done_q <= 1'b1;
					end else begin
						in_row_q <= in_row_q + RW'(1);
					end
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (ctl.emit) begin
				if (out_col_q >= wm1) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RW'(1);
					out_rb_q  <= (out_rb_inc >= AX'(DEPTH)) ? AW'(out_rb_inc - AX'(DEPTH))
						: AW'(out_rb_inc);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// Readiness: the clamped lower-right corner of the window has arrived.
	logic [RW-1:0] need_r;
	logic [CW-1:0] need_c;

	always_comb begin
		if (32'(out_row_q) + 32'(half) > 32'(hm1)) begin
			need_r = hm1;
		end else begin
			need_r = RW'(32'(out_row_q) + 32'(half));
		end
		if (32'(out_col_q) + 32'(half) > 32'(wm1)) begin
			need_c = wm1;
		end else begin
			need_c = CW'(32'(out_col_q) + 32'(half));
		end
	end

	// Window walk registers.
	logic [AW-1:0]  rb_q;
	logic [RW-1:0]  y_q;
	logic [SDW-1:0] k_q, dx_q, dy_q, k_init;
	logic [AX-1:0]  rb_inc, rb_dec, rd_sum;
	logic [CW-1:0]  x;
	logic [AW-1:0]  rd_addr;
	logic [31:0]    xt;

	assign k_init = (32'(out_row_q) < 32'(half)) ? SDW'(out_row_q) : half;
	assign rb_inc = AX'(rb_q) + AX'(w);
	assign rb_dec = (AX'(rb_q) >= AX'(w)) ? AX'(rb_q) - AX'(w)
		: AX'(rb_q) + AX'(DEPTH) - AX'(w);

	// Clamped column and ring address of the current window tap.
	always_comb begin
		xt = 32'(out_col_q) + 32'(dx_q);
		if (xt < 32'(half)) begin
			x = '0;
		end else if (xt - 32'(half) > 32'(wm1)) begin
			x = wm1;
		end else begin
			x = CW'(xt - 32'(half));
		end
		rd_sum  = AX'(rb_q) + AX'(x);
		rd_addr = (rd_sum >= AX'(DEPTH)) ? AW'(rd_sum - AX'(DEPTH)) : AW'(rd_sum);
	end

	// Window rows above the frame repeat row zero; rows below it repeat the last row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rb_q <= '0;
			y_q  <= '0;
			k_q  <= '0;
			dx_q <= '0;
			dy_q <= '0;
		end else if (ctl.win_init) begin
			rb_q <= out_rb_q;
			k_q  <= k_init;
			y_q  <= out_row_q - RW'(k_init);
			dx_q <= '0;
			dy_q <= '0;
		end else if (ctl.back_step) begin
			rb_q <= AW'(rb_dec);
			k_q  <= k_q - SDW'(1);
		end else if (ctl.read_step) begin
			if (dx_q == side_m1) begin
				dx_q <= '0;
				dy_q <= dy_q + SDW'(1);
				if ((32'(out_row_q) + 32'(dy_q) >= 32'(half)) && (y_q < hm1)) begin
					y_q  <= y_q + RW'(1);
					rb_q <= (rb_inc >= AX'(DEPTH)) ? AW'(rb_inc - AX'(DEPTH)) : AW'(rb_inc);
				end
			end else begin
				dx_q <= dx_q + SDW'(1);
			end
		end
	end

	// Line store: one write port for incoming pixels, one registered read port.
	logic [rbb_pkg::PIX_W-1:0] line_mem [DEPTH];
	logic [rbb_pkg::PIX_W-1:0] rd_data_s1;
	logic                      rd_v_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr_pix) begin
			line_mem[in_addr_q] <= {pix_red, pix_green, pix_blue};
		end
		if (ctl.read_step) begin
			rd_data_s1 <= line_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= ctl.read_step;
		end
	end

	// Per-channel window sums and restoring dividers with a shared divisor register and step counter.
	logic [SUM_W-1:0]          sum_q [3];
	logic [SUM_W-1:0]          rem_q [3];
	logic [rbb_pkg::QUOT_W-1:0] quo_q [3];
	logic [SUM_W-1:0]          dsh_q;
	logic [DCW-1:0]            div_cnt_q;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (ctl.win_init) begin
				sum_q[c] <= '0;
			end else if (rd_v_s1) begin
				sum_q[c] <= sum_q[c] + SUM_W'(rd_data_s1[(2 - c) * CH +: CH]);
			end
			if (ctl.div_init) begin
				rem_q[c] <= sum_q[c];
				quo_q[c] <= '0;
			end else if (ctl.div_step) begin
				if (rem_q[c] >= dsh_q) begin
					rem_q[c] <= rem_q[c] - dsh_q;
					quo_q[c] <= {quo_q[c][rbb_pkg::QUOT_W-2:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][rbb_pkg::QUOT_W-2:0], 1'b0};
				end
			end
		end
		if (ctl.div_init) begin
			dsh_q <= SUM_W'(32'(area) << (rbb_pkg::QUOT_W - 1));
		end else if (ctl.div_step) begin
			dsh_q <= dsh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (ctl.div_init) begin
			div_cnt_q <= '0;
		end else if (ctl.div_step) begin
			div_cnt_q <= div_cnt_q + DCW'(1);
		end
	end

	// Output register: holds a finished result until the sink takes it.
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_red       <= quo_q[0];
			out_green     <= quo_q[1];
			out_blue      <= quo_q[2];
			out_frame_end <= last_px;
		end
	end

	assign out_valid = out_valid_q;

	// Status back to the controller.
	always_comb begin
		stat.in_done    = in_done_q;
		stat.emit_ready = in_done_q || (in_row_q > need_r)
			|| ((in_row_q == need_r) && (in_col_q > need_c));
		stat.k_zero     = (k_q == '0);
		stat.win_last   = (dx_q == side_m1) && (dy_q == side_m1);
		stat.div_last   = (32'(div_cnt_q) == rbb_pkg::QUOT_W - 1);
		stat.out_free   = !out_valid_q || out_ready;
	end

	// A window read always lands inside the ring.
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.read_step |-> (32'(rd_addr) < DEPTH && dy_q < side))
		else $error("window read beyond the line store");

	// A completed frame leaves the input position on the last row, column zero.
	a_done_pos: assert property (@(posedge clk) disable iff (!arst_n)
		in_done_q |-> (in_col_q == '0 && in_row_q == hm1))
		else $error("input done flag with unexpected position");

	// The last result of a frame restarts every position.
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && last_px) |=> (!in_done_q && out_row_q == '0 && out_col_q == '0
			&& in_row_q == '0 && in_col_q == '0))
		else $error("frame did not restart after its last result");

	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || out_ready))
		else $error("result overwritten in output register");

endmodule

[design/rgb_box_blur_clamped_top.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload                                    Handshake
// pixels    in   cmd, in_red, in_green, in_blue             valid / ready
// blurred   out  out_red, out_green, out_blue, frame_end    valid / ready
// cfg       in   cfg_index, cfg_data                        cfg_we, no stall
//
// A request that yields no result returns from the check state to idle. One that
// yields a result walks back k = min(S/2, output row) rows, S the window side, then
// reads the window through the single read port of the line store, one pixel per
// cycle, and runs the divider, which produces one quotient bit per cycle.
// Reset clears control state and loads radius 1, width 640, height 480; the line
// store is not cleared. A result waits in an output register, and the next request
// is taken meanwhile; the block only waits on the sink when a second result is ready first.
module rgb_box_blur_clamped_top #(
	parameter int MAX_RADIUS = 7,
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	rbb_pix_if.sink                         pixels,
	rbb_out_if.source                       blurred,
	input  logic                            cfg_we,
	input  logic [rbb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rbb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	rbb_pkg::ctrl_cmd_t ctl;
	rbb_pkg::dp_stat_t  stat;

	// Request sequencer.
	rbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_cmd   (pixels.cmd),
		.in_ready (pixels.ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// Line store, window sums, divider and output register.
	rbb_dp #(
		.MAX_RADIUS (MAX_RADIUS),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pix_red       (pixels.in_red),
		.pix_green     (pixels.in_green),
		.pix_blue      (pixels.in_blue),
		.ctl           (ctl),
		.stat          (stat),
		.out_ready     (blurred.ready),
		.out_valid     (blurred.valid),
		.out_red       (blurred.out_red),
		.out_green     (blurred.out_green),
		.out_blue      (blurred.out_blue),
		.out_frame_end (blurred.frame_end)
	);

endmodule
